@@ rtl/core/mer_pkg.sv @@
// shared types and constants for the midpoint ellipse rasterizer
package mer_pkg;

	localparam int COORD_BITS = 10;
	localparam int CTR_W      = 11;
	localparam int PIX_W      = 12;

	localparam int SQ_W   = 2 * COORD_BITS;
	localparam int TX_W   = COORD_BITS + 1;
	localparam int MA_W   = 3 * COORD_BITS + 1;
	localparam int MB_W   = SQ_W;
	localparam int PROD_W = MA_W + MB_W;
	localparam int DEC_W  = 4 * COORD_BITS + 8;
	localparam int GD_W   = 3 * COORD_BITS + 3;

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	typedef logic [COORD_BITS-1:0]    coord_t;
	typedef logic [SQ_W-1:0]          sq_t;
	typedef logic [TX_W-1:0]          tx_t;
	typedef logic [MA_W-1:0]          mula_t;
	typedef logic [MB_W-1:0]          mulb_t;
	typedef logic [PROD_W-1:0]        prod_t;
	typedef logic signed [DEC_W-1:0]  dec_t;
	typedef logic signed [GD_W-1:0]   gd_t;
	typedef logic signed [CTR_W-1:0]  ctr_t;
	typedef logic signed [PIX_W-1:0]  pix_t;
	typedef logic [CMDQ_PTR_W-1:0]    ptr_t;
	typedef logic [CMDQ_CNT_W-1:0]    cnt_t;

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} op_t;

	typedef struct packed {
		op_t    op;
		coord_t axis_a;
		coord_t axis_b;
		ctr_t   centre_x;
		ctr_t   centre_y;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmdq_head_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT0,
		ST_INIT1,
		ST_INIT2,
		ST_INIT3,
		ST_TRN0,
		ST_TRN1,
		ST_TRN2,
		ST_TRN3,
		ST_TRN4,
		ST_TRN5
	} seq_state_t;

endpackage

@@ rtl/core/mer_front.sv @@
// front end: accepts commands, decodes them and queues them for the sequencer
module mer_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic                  command,
	input  logic [9:0]            semi_axis_x,
	input  logic [9:0]            semi_axis_y,
	input  logic signed [10:0]    centre_x,
	input  logic signed [10:0]    centre_y,
	output mer_pkg::cmdq_head_t   head,
	input  logic                  head_pop
);

	mer_pkg::cmd_t slot_q [mer_pkg::CMDQ_DEPTH];
	mer_pkg::ptr_t wr_ptr_q;
	mer_pkg::ptr_t rd_ptr_q;
	mer_pkg::cnt_t count_q;
	mer_pkg::cmd_t in_cmd;
	logic          do_push;
	logic          do_pop;

	always_comb begin
		in_cmd.op       = command ? mer_pkg::OP_STEP : mer_pkg::OP_START;
		in_cmd.axis_a   = mer_pkg::coord_t'(semi_axis_x);
		in_cmd.axis_b   = mer_pkg::coord_t'(semi_axis_y);
		in_cmd.centre_x = centre_x;
		in_cmd.centre_y = centre_y;
	end

	assign full       = (count_q == mer_pkg::cnt_t'(mer_pkg::CMDQ_DEPTH));
	assign do_push    = push && !full;
	assign head.valid = (count_q != '0);
	assign head.cmd   = slot_q[rd_ptr_q];
	assign do_pop     = head_pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == mer_pkg::ptr_t'(mer_pkg::CMDQ_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == mer_pkg::ptr_t'(mer_pkg::CMDQ_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/core/mer_mul.sv @@
// shared unsigned multiplier with registered product
module mer_mul (
	input  logic            clk,
	input  mer_pkg::mula_t  op_a,
	input  mer_pkg::mulb_t  op_b,
	output mer_pkg::prod_t  prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= mer_pkg::prod_t'(op_a) * mer_pkg::prod_t'(op_b);
	end

endmodule

@@ rtl/core/mer_back.sv @@
// back end: point sequencer, decision datapath and result register
module mer_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mer_pkg::cmdq_head_t  head,
	output logic                 head_pop,
	output logic                 empty,
	input  logic                 pop,
	output logic                 point_valid,
	output logic signed [11:0]   px_right,
	output logic signed [11:0]   py_up,
	output logic signed [11:0]   px_left,
	output logic signed [11:0]   py_down,
	output logic                 last_point
);

	mer_pkg::seq_state_t state_q, state_d;
	logic                active_q, active_d;
	logic                r2_q, r2_d;
	mer_pkg::coord_t     offset_x_q, offset_x_d;
	mer_pkg::coord_t     offset_y_q, offset_y_d;
	mer_pkg::coord_t     axis_a_q, axis_a_d;
	mer_pkg::coord_t     axis_b_q, axis_b_d;
	mer_pkg::sq_t        axx_q, axx_d;
	mer_pkg::sq_t        ayy_q, ayy_d;
	mer_pkg::ctr_t       cx_q, cx_d;
	mer_pkg::ctr_t       cy_q, cy_d;
	mer_pkg::dec_t       dec_q, dec_d;
	mer_pkg::dec_t       incx_q, incx_d;
	mer_pkg::dec_t       incy_q, incy_d;
	mer_pkg::dec_t       t1_q, t1_d;
	mer_pkg::gd_t        gdiff_q, gdiff_d;

	logic                out_valid_q;
	logic                point_valid_q;
	logic                last_point_q;
	mer_pkg::pix_t       px_right_q, py_up_q, px_left_q, py_down_q;

	mer_pkg::mula_t      mul_a;
	mer_pkg::mulb_t      mul_b;
	mer_pkg::prod_t      prod;

	logic                out_free;
	logic                load_out;
	logic                ld_valid;
	logic                ld_last;
	logic                ld_zero;
	logic                dec_neg;
	logic                gdiff_pos;
	mer_pkg::tx_t        tx;
	mer_pkg::coord_t     ty_abs;
	mer_pkg::dec_t       axx_dec, ayy_dec, prod_dec;
	mer_pkg::gd_t        axx_gd, ayy_gd;
	mer_pkg::pix_t       cx_pix, cy_pix, ox_pix, oy_pix;

	mer_mul u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (prod)
	);

	assign out_free  = !out_valid_q || pop;
	assign dec_neg   = dec_q[mer_pkg::DEC_W-1];
	assign gdiff_pos = !gdiff_q[mer_pkg::GD_W-1] && (gdiff_q != '0);
	assign tx        = {offset_x_q, 1'b1};
	// (y - 1)^2 with y = 0 squares minus one
	assign ty_abs    = (offset_y_q == '0) ? mer_pkg::coord_t'(1) : offset_y_q - 1'b1;
	assign axx_dec   = mer_pkg::dec_t'(axx_q);
	assign ayy_dec   = mer_pkg::dec_t'(ayy_q);
	assign prod_dec  = mer_pkg::dec_t'(prod);
	assign axx_gd    = mer_pkg::gd_t'(axx_q);
	assign ayy_gd    = mer_pkg::gd_t'(ayy_q);
	assign cx_pix    = mer_pkg::pix_t'(cx_q);
	assign cy_pix    = mer_pkg::pix_t'(cy_q);
	assign ox_pix    = mer_pkg::pix_t'(offset_x_q);
	assign oy_pix    = mer_pkg::pix_t'(offset_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mer_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// incx and incy hold the next decision increments for an x step and a y step
	always_comb begin
		state_d    = state_q;
		active_d   = active_q;
		r2_d       = r2_q;
		offset_x_d = offset_x_q;
		offset_y_d = offset_y_q;
		axis_a_d   = axis_a_q;
		axis_b_d   = axis_b_q;
		axx_d      = axx_q;
		ayy_d      = ayy_q;
		cx_d       = cx_q;
		cy_d       = cy_q;
		dec_d      = dec_q;
		incx_d     = incx_q;
		incy_d     = incy_q;
		t1_d       = t1_q;
		gdiff_d    = gdiff_q;
		head_pop   = 1'b0;
		load_out   = 1'b0;
		ld_valid   = 1'b0;
		ld_last    = 1'b0;
		ld_zero    = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		case (state_q)
			mer_pkg::ST_IDLE: begin
				if (head.valid && out_free) begin
					case (head.cmd.op)
						mer_pkg::OP_START: begin
							head_pop = 1'b1;
							axis_a_d = head.cmd.axis_a;
							axis_b_d = head.cmd.axis_b;
							cx_d     = head.cmd.centre_x;
							cy_d     = head.cmd.centre_y;
							state_d  = mer_pkg::ST_INIT0;
						end
						mer_pkg::OP_STEP: begin
							if (!active_q) begin
								head_pop = 1'b1;
								load_out = 1'b1;
								ld_last  = 1'b1;
								ld_zero  = 1'b1;
							end else if (!r2_q && gdiff_pos) begin
								// region 1: x always advances
								head_pop   = 1'b1;
								load_out   = 1'b1;
								ld_valid   = 1'b1;
								offset_x_d = offset_x_q + 1'b1;
								incx_d     = incx_q + (ayy_dec << 3);
								if (dec_neg) begin
									dec_d   = dec_q + incx_q;
									gdiff_d = gdiff_q - (ayy_gd << 1);
								end else begin
									offset_y_d = offset_y_q - 1'b1;
									incy_d     = incy_q + (axx_dec << 3);
									gdiff_d    = gdiff_q - (ayy_gd << 1) - (axx_gd << 1);
									dec_d      = dec_q + incx_q + incy_q;
								end
							end else if (!r2_q) begin
								state_d = mer_pkg::ST_TRN0;
							end else if (offset_y_q == '0) begin
								head_pop = 1'b1;
								load_out = 1'b1;
								ld_valid = 1'b1;
								ld_last  = 1'b1;
								active_d = 1'b0;
								r2_d     = 1'b0;
							end else begin
								// region 2: y always advances
								head_pop   = 1'b1;
								load_out   = 1'b1;
								ld_valid   = 1'b1;
								offset_y_d = offset_y_q - 1'b1;
								incy_d     = incy_q + (axx_dec << 3);
								if (!dec_neg) begin
									dec_d = dec_q + incy_q;
								end else begin
									offset_x_d = offset_x_q + 1'b1;
									incx_d     = incx_q + (ayy_dec << 3);
									dec_d      = dec_q + incy_q + incx_q;
								end
							end
						end
						default: begin
							state_d = mer_pkg::ST_IDLE;
						end
					endcase
				end
			end
			mer_pkg::ST_INIT0: begin
				mul_a   = mer_pkg::mula_t'(axis_a_q);
				mul_b   = mer_pkg::mulb_t'(axis_a_q);
				state_d = mer_pkg::ST_INIT1;
			end
			mer_pkg::ST_INIT1: begin
				axx_d   = mer_pkg::sq_t'(prod);
				mul_a   = mer_pkg::mula_t'(axis_b_q);
				mul_b   = mer_pkg::mulb_t'(axis_b_q);
				state_d = mer_pkg::ST_INIT2;
			end
			mer_pkg::ST_INIT2: begin
				ayy_d   = mer_pkg::sq_t'(prod);
				mul_a   = mer_pkg::mula_t'(axx_q);
				mul_b   = mer_pkg::mulb_t'(axis_b_q);
				state_d = mer_pkg::ST_INIT3;
			end
			mer_pkg::ST_INIT3: begin
				// prod holds a^2 * b
				gdiff_d    = mer_pkg::gd_t'(prod) << 1;
				incx_d     = (ayy_dec << 3) + (ayy_dec << 2);
				incy_d     = (axx_dec << 3) - (prod_dec << 3);
				dec_d      = (ayy_dec << 2) - (prod_dec << 2) + axx_dec;
				offset_x_d = '0;
				offset_y_d = axis_b_q;
				active_d   = 1'b1;
				r2_d       = 1'b0;
				load_out   = 1'b1;
				ld_zero    = 1'b1;
				state_d    = mer_pkg::ST_IDLE;
			end
			mer_pkg::ST_TRN0: begin
				mul_a   = mer_pkg::mula_t'(ayy_q);
				mul_b   = mer_pkg::mulb_t'(tx);
				state_d = mer_pkg::ST_TRN1;
			end
			mer_pkg::ST_TRN1: begin
				mul_a   = mer_pkg::mula_t'(prod);
				mul_b   = mer_pkg::mulb_t'(tx);
				state_d = mer_pkg::ST_TRN2;
			end
			mer_pkg::ST_TRN2: begin
				t1_d    = prod_dec;
				mul_a   = mer_pkg::mula_t'(ty_abs);
				mul_b   = mer_pkg::mulb_t'(ty_abs);
				state_d = mer_pkg::ST_TRN3;
			end
			mer_pkg::ST_TRN3: begin
				mul_a   = mer_pkg::mula_t'(axx_q);
				mul_b   = mer_pkg::mulb_t'(prod);
				state_d = mer_pkg::ST_TRN4;
			end
			mer_pkg::ST_TRN4: begin
				t1_d    = t1_q + (prod_dec << 2);
				mul_a   = mer_pkg::mula_t'(axx_q);
				mul_b   = mer_pkg::mulb_t'(ayy_q);
				state_d = mer_pkg::ST_TRN5;
			end
			mer_pkg::ST_TRN5: begin
				// rebase the increments onto the region 2 update rules
				dec_d   = t1_q - (prod_dec << 2);
				incx_d  = incx_q - (ayy_dec << 2);
				incy_d  = incy_q + (axx_dec << 2);
				r2_d    = 1'b1;
				state_d = mer_pkg::ST_IDLE;
			end
			default: begin
				state_d = mer_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			r2_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			active_q <= active_d;
			r2_q     <= r2_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		offset_x_q <= offset_x_d;
		offset_y_q <= offset_y_d;
		axis_a_q   <= axis_a_d;
		axis_b_q   <= axis_b_d;
		axx_q      <= axx_d;
		ayy_q      <= ayy_d;
		cx_q       <= cx_d;
		cy_q       <= cy_d;
		dec_q      <= dec_d;
		incx_q     <= incx_d;
		incy_q     <= incy_d;
		t1_q       <= t1_d;
		gdiff_q    <= gdiff_d;
		if (load_out) begin
			point_valid_q <= ld_valid;
			last_point_q  <= ld_last;
			if (ld_zero) begin
				px_right_q <= '0;
				py_up_q    <= '0;
				px_left_q  <= '0;
				py_down_q  <= '0;
			end else begin
				px_right_q <= cx_pix + ox_pix;
				py_up_q    <= cy_pix + oy_pix;
				px_left_q  <= cx_pix - ox_pix;
				py_down_q  <= cy_pix - oy_pix;
			end
		end
	end

	assign empty       = !out_valid_q;
	assign point_valid = point_valid_q;
	assign last_point  = last_point_q;
	assign px_right    = px_right_q;
	assign py_up       = py_up_q;
	assign px_left     = px_left_q;
	assign py_down     = py_down_q;

`ifndef SYNTHESIS
	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		head_pop |-> state_q == mer_pkg::ST_IDLE)
		else $error("command taken outside idle state");

	a_trn_needs_r1: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mer_pkg::ST_TRN0 |-> active_q && !r2_q)
		else $error("region change started without an active region 1 ellipse");

	a_trn_ends_r2: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mer_pkg::ST_TRN5 |=> r2_q && state_q == mer_pkg::ST_IDLE)
		else $error("region change did not land in region 2");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !out_valid_q || pop)
		else $error("result register overwritten");

	a_ack_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mer_pkg::ST_INIT3 |=> active_q && out_valid_q && !point_valid_q)
		else $error("start did not produce an acknowledge");
`endif

endmodule

@@ rtl/core/midpoint_ellipse_rasterizer.sv @@
// top level of the midpoint ellipse rasterizer
//
//  channel   direction  handshake        transaction payload
//  command   in         push / full      command, semi_axis_x/y, centre_x/y
//  result    out        pop / empty      point_valid, px_right, py_up, px_left, py_down,
//                                        last_point
//
// commands enter a two-entry queue; the sequencer behind it takes one at a time.
// a step in region 1 or region 2 is done in the idle state; a start goes through the
// init states (three products through the shared multiplier, then the set-up).
// the step that crosses into region 2 first runs the transition states on the multiplier.
// a result waits in a single output register; the sequencer holds while it is full.
// reset empties the queue and the output register and leaves no ellipse active.
module midpoint_ellipse_rasterizer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic                command,
	input  logic [9:0]          semi_axis_x,
	input  logic [9:0]          semi_axis_y,
	input  logic signed [10:0]  centre_x,
	input  logic signed [10:0]  centre_y,
	output logic                empty,
	input  logic                pop,
	output logic                point_valid,
	output logic signed [11:0]  px_right,
	output logic signed [11:0]  py_up,
	output logic signed [11:0]  px_left,
	output logic signed [11:0]  py_down,
	output logic                last_point
);

	mer_pkg::cmdq_head_t head;
	logic                head_pop;

	mer_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.command     (command),
		.semi_axis_x (semi_axis_x),
		.semi_axis_y (semi_axis_y),
		.centre_x    (centre_x),
		.centre_y    (centre_y),
		.head        (head),
		.head_pop    (head_pop)
	);

	mer_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_pop    (head_pop),
		.empty       (empty),
		.pop         (pop),
		.point_valid (point_valid),
		.px_right    (px_right),
		.py_up       (py_up),
		.px_left     (px_left),
		.py_down     (py_down),
		.last_point  (last_point)
	);

endmodule
